[hdl/gated_weighted_histogram_unit_macros.svh]
// Assertion macros used by the checker of the gated weighted histogram unit.
`ifndef GATED_WEIGHTED_HISTOGRAM_UNIT_MACROS_SVH
`define GATED_WEIGHTED_HISTOGRAM_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GWH_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define GWH_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define GWH_ASSERT_SAME(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

`endif

[hdl/gwh_pkg.sv]
// Types and constants shared by the gated weighted histogram unit.
`timescale 1ns / 1ps

package gwh_pkg;

   localparam int NUM_COLOUR = 4;
   localparam int FRAC_BITS  = 12;
   localparam int VAL_W      = 37;
   localparam int BIN_RAW_W  = VAL_W - 1 - FRAC_BITS;

   localparam logic [1:0] KIND_MAP  = 2'd0;
   localparam logic [1:0] KIND_HIT  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] CSR_SCALE = 2'd0;
   localparam logic [1:0] CSR_SHIFT = 2'd1;

   localparam logic [15:0] SCALE_RESET = 16'd256;
   localparam logic [31:0] SHIFT_RESET = 32'd0;

   typedef struct packed {
      logic                 in_range;
      logic [BIN_RAW_W-1:0] bin;
   } bin_info_type;

endpackage

[hdl/gwh_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module gwh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/gwh_binmap.sv]
// Two-stage energy-to-bin mapping: registered product, then offset and range check.
`timescale 1ns / 1ps

module gwh_binmap #(
   parameter int BINS = 4096
) (
   input  logic                clock,
   input  logic signed [19:0]  energy,
   input  logic [15:0]         scale,
   input  logic signed [31:0]  shift,
   output gwh_pkg::bin_info_type bin_info
);

   logic signed [gwh_pkg::VAL_W-1:0] prod_in;
   logic signed [gwh_pkg::VAL_W-1:0] prod_ff;
   logic signed [gwh_pkg::VAL_W-1:0] val;
   gwh_pkg::bin_info_type            info_in;
   gwh_pkg::bin_info_type            info_ff;

   always_comb begin
      prod_in = gwh_pkg::VAL_W'(energy) * gwh_pkg::VAL_W'($signed({1'b0, scale}));
      val     = prod_ff + gwh_pkg::VAL_W'(shift);
      info_in.bin      = val[gwh_pkg::VAL_W-2:gwh_pkg::FRAC_BITS];
      info_in.in_range = !val[gwh_pkg::VAL_W-1] && (32'(info_in.bin) < BINS);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      info_ff <= info_in;
   end

   assign bin_info = info_ff;

endmodule

[hdl/gated_weighted_histogram_unit.sv]
// Top level of the gated weighted histogram unit: sequencer, registers and memories.
`timescale 1ns / 1ps

// Channel        | Ports                              | Handshake
// ---------------+------------------------------------+-------------------------------
// request        | req_* fields                       | start high while busy is low
// response       | rsp_bin_value, rsp_group_hits, ... | rsp_valid for one cycle
// configuration  | csr_index, csr_wdata               | csr_write_en, no wait
//
// Every memory read is registered, so a hit runs through lookup, bin and update steps;
// a read goes from decode straight to update, and a map write ends in decode.
// A request rejected for an out-of-range index is answered from decode.
// After reset a clearing pass over every address of the largest memory zeroes all
// memories while busy stays high.
// The receiver cannot stall: each response transaction is taken in its strobe cycle.

module gated_weighted_histogram_unit #(
   parameter int NUM_GROUPS = 8,
   parameter int BINS       = 4096,
   parameter int NUM_POS    = 16,
   parameter int NUM_RECOIL = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [4:0]         req_position,
   input  logic [2:0]         req_colour,
   input  logic [4:0]         req_recoil_det,
   input  logic [2:0]         req_map_group,
   input  logic signed [19:0] req_energy,
   input  logic signed [15:0] req_weight,
   input  logic [11:0]        req_read_bin,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_bin_value,
   output logic [31:0]        rsp_group_hits,
   output logic [1:0]         rsp_status
);

   localparam int TBL_DEPTH  = NUM_POS * gwh_pkg::NUM_COLOUR * NUM_RECOIL;
   localparam int SPEC_DEPTH = NUM_GROUPS * BINS;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int SPEC_AW    = (SPEC_DEPTH > 1) ? $clog2(SPEC_DEPTH) : 1;
   localparam int BIN_AW     = $clog2(BINS);
   localparam int CLR_LEN    = (TBL_DEPTH > SPEC_DEPTH) ? TBL_DEPTH : SPEC_DEPTH;
   localparam int CLR_W      = $clog2(CLR_LEN);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_BIN,
      S_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [15:0]        scale_ff;
   logic signed [31:0] shift_ff;

   logic [1:0]         kind_ff;
   logic [4:0]         pos_ff;
   logic [2:0]         col_ff;
   logic [4:0]         rec_ff;
   logic [2:0]         grp_ff;
   logic signed [19:0] energy_ff;
   logic signed [15:0] weight_ff;
   logic [11:0]        rbin_ff;
   logic [GRP_W-1:0]   g_ff, g_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_bin_ff, rsp_bin_in;
   logic [31:0]        rsp_hits_ff, rsp_hits_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               clearing;
   logic               tbl_valid;
   logic               grp_ok;
   logic               rbin_ok;
   logic               hit_neg;
   logic [TBL_AW-1:0]  tbl_idx;
   logic [GRP_W-1:0]   sel_grp;
   logic [BIN_AW-1:0]  sel_bin;
   logic [SPEC_AW-1:0] spec_addr;
   logic signed [32:0] bin_sum;
   logic signed [31:0] bin_new;
   logic [31:0]        cnt_inc;

   logic               tbl_we;
   logic [TBL_AW-1:0]  tbl_waddr;
   logic [GRP_W-1:0]   tbl_wdata;
   logic [GRP_W-1:0]   tbl_rdata;
   logic               cnt_we;
   logic [GRP_W-1:0]   cnt_waddr;
   logic [31:0]        cnt_wdata;
   logic [31:0]        cnt_rdata;
   logic               spec_we;
   logic [SPEC_AW-1:0] spec_waddr;
   logic [31:0]        spec_wdata;
   logic [31:0]        spec_rdata;

   gwh_pkg::bin_info_type bin_info;

   gwh_binmap #(
      .BINS(BINS)
   ) u_binmap (
      .clock   (clock),
      .energy  (energy_ff),
      .scale   (scale_ff),
      .shift   (shift_ff),
      .bin_info(bin_info)
   );

   gwh_ram #(
      .WIDTH(GRP_W),
      .DEPTH(TBL_DEPTH)
   ) u_group_table (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_waddr),
      .wr_data(tbl_wdata),
      .rd_addr(tbl_idx),
      .rd_data(tbl_rdata)
   );

   gwh_ram #(
      .WIDTH(32),
      .DEPTH(NUM_GROUPS)
   ) u_group_counters (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata),
      .rd_addr(sel_grp),
      .rd_data(cnt_rdata)
   );

   gwh_ram #(
      .WIDTH(32),
      .DEPTH(SPEC_DEPTH)
   ) u_spectrum_store (
      .clock  (clock),
      .wr_en  (spec_we),
      .wr_addr(spec_waddr),
      .wr_data(spec_wdata),
      .rd_addr(spec_addr),
      .rd_data(spec_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= gwh_pkg::SCALE_RESET;
         shift_ff <= gwh_pkg::SHIFT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gwh_pkg::CSR_SCALE: scale_ff <= csr_wdata[15:0];
            gwh_pkg::CSR_SHIFT: shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      accept   = start && !busy;
      clearing = (state_ff == S_CLEAR);
      hit_neg  = energy_ff[19];

      tbl_valid = (pos_ff != 5'd0) && (32'(pos_ff) <= NUM_POS)
               && (32'(col_ff) < gwh_pkg::NUM_COLOUR)
               && (rec_ff != 5'd0) && (32'(rec_ff) <= NUM_RECOIL);
      tbl_idx   = TBL_AW'((TBL_AW'(pos_ff) - TBL_AW'(1)) * TBL_AW'(gwh_pkg::NUM_COLOUR)
                  + TBL_AW'(col_ff));
      tbl_idx   = TBL_AW'(tbl_idx * TBL_AW'(NUM_RECOIL) + TBL_AW'(rec_ff) - TBL_AW'(1));
      grp_ok    = 32'(grp_ff) < NUM_GROUPS;
      rbin_ok   = 32'(rbin_ff) < BINS;

      sel_grp   = (state_ff == S_DECODE) ? GRP_W'(grp_ff) : g_ff;
      sel_bin   = (state_ff == S_DECODE) ? BIN_AW'(rbin_ff) : bin_info.bin[BIN_AW-1:0];
      spec_addr = SPEC_AW'(SPEC_AW'(sel_grp) * SPEC_AW'(BINS)) + SPEC_AW'(sel_bin);

      bin_sum = 33'($signed(spec_rdata)) + 33'(weight_ff);
      if (bin_sum[32] != bin_sum[31]) begin
         bin_new = bin_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         bin_new = bin_sum[31:0];
      end
      cnt_inc = (cnt_rdata == 32'hFFFFFFFF) ? cnt_rdata : cnt_rdata + 32'd1;

      tbl_we    = clearing ? (32'(clr_ff) < TBL_DEPTH)
                           : ((state_ff == S_DECODE) && (kind_ff == gwh_pkg::KIND_MAP)
                              && tbl_valid && grp_ok);
      tbl_waddr = clearing ? clr_ff[TBL_AW-1:0] : tbl_idx;
      tbl_wdata = clearing ? '0 : GRP_W'(grp_ff);

      cnt_we    = clearing ? (32'(clr_ff) < NUM_GROUPS)
                           : ((state_ff == S_UPDATE) && (kind_ff == gwh_pkg::KIND_HIT)
                              && !hit_neg);
      cnt_waddr = clearing ? clr_ff[GRP_W-1:0] : g_ff;
      cnt_wdata = clearing ? 32'd0 : cnt_inc;

      spec_we    = clearing ? (32'(clr_ff) < SPEC_DEPTH)
                            : ((state_ff == S_UPDATE) && (kind_ff == gwh_pkg::KIND_HIT)
                               && !hit_neg && bin_info.in_range);
      spec_waddr = clearing ? clr_ff[SPEC_AW-1:0] : spec_addr;
      spec_wdata = clearing ? 32'd0 : bin_new;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      g_in          = g_ff;
      rsp_valid_in  = 1'b0;
      rsp_bin_in    = 32'sd0;
      rsp_hits_in   = 32'd0;
      rsp_status_in = gwh_pkg::ST_RANGE;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (kind_ff)
               gwh_pkg::KIND_MAP: begin
                  rsp_status_in = (tbl_valid && grp_ok) ? gwh_pkg::ST_OK : gwh_pkg::ST_RANGE;
               end
               gwh_pkg::KIND_HIT: begin
                  if (tbl_valid) begin
                     state_in     = S_LOOKUP;
                     rsp_valid_in = 1'b0;
                  end
               end
               gwh_pkg::KIND_READ: begin
                  if (grp_ok && rbin_ok) begin
                     state_in     = S_UPDATE;
                     rsp_valid_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         S_LOOKUP: begin
            g_in     = tbl_rdata;
            state_in = S_BIN;
         end
         S_BIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (kind_ff == gwh_pkg::KIND_READ) begin
               rsp_bin_in    = $signed(spec_rdata);
               rsp_hits_in   = cnt_rdata;
               rsp_status_in = gwh_pkg::ST_OK;
            end else if (hit_neg) begin
               rsp_hits_in   = cnt_rdata;
               rsp_status_in = gwh_pkg::ST_SKIP;
            end else begin
               rsp_hits_in = cnt_inc;
               if (bin_info.in_range) begin
                  rsp_bin_in    = bin_new;
                  rsp_status_in = gwh_pkg::ST_OK;
               end else begin
                  rsp_status_in = gwh_pkg::ST_SKIP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         g_ff          <= g_in;
         rsp_bin_ff    <= rsp_bin_in;
         rsp_hits_ff   <= rsp_hits_in;
         rsp_status_ff <= rsp_status_in;
         if (accept) begin
            kind_ff   <= req_kind;
            pos_ff    <= req_position;
            col_ff    <= req_colour;
            rec_ff    <= req_recoil_det;
            grp_ff    <= req_map_group;
            energy_ff <= req_energy;
            weight_ff <= req_weight;
            rbin_ff   <= req_read_bin;
         end
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_value  = rsp_bin_ff;
   assign rsp_group_hits = rsp_hits_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[hdl/gwh_checker.sv]
// Port-level checker for the gated weighted histogram unit and its bind statement.
`timescale 1ns / 1ps
`include "gated_weighted_histogram_unit_macros.svh"

module gwh_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_bin_value,
   input logic [31:0] rsp_group_hits,
   input logic [1:0]  rsp_status
);

   `GWH_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "busy did not rise after a transaction was accepted")
   `GWH_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "response strobe lasted longer than one cycle")
   `GWH_ASSERT_SAME(a_strobe_when_free, rsp_valid, !busy, "response strobe while still busy")
   `GWH_ASSERT_ALWAYS(a_range_zero, !(rsp_valid && (rsp_status == gwh_pkg::ST_RANGE)) || ((rsp_bin_value == 32'd0) && (rsp_group_hits == 32'd0)), "out-of-range response carries data")

endmodule

bind gated_weighted_histogram_unit gwh_checker u_gwh_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_bin_value (rsp_bin_value),
   .rsp_group_hits(rsp_group_hits),
   .rsp_status    (rsp_status)
);

[dv/testbench.sv]
// Self-checking testbench for the gated weighted histogram unit with its own histogram predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_GROUPS = 8;
   localparam int BINS       = 4096;
   localparam int NUM_POS    = 16;
   localparam int NUM_RECOIL = 24;
   localparam int TABLE_SIZE = NUM_POS * gwh_pkg::NUM_COLOUR * NUM_RECOIL;
   localparam int MAX_REPORTS = 10;
   localparam int HEAVY_HITS = 20;
   localparam int PHASE_ITEMS = 250;
   localparam int NUM_PHASES = 7;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [1:0]         kind;
      logic [4:0]         position;
      logic [2:0]         colour;
      logic [4:0]         recoil_det;
      logic [2:0]         map_group;
      logic signed [19:0] energy;
      logic signed [15:0] weight;
      logic [11:0]        read_bin;
   } hist_request_type;

   typedef struct {
      logic signed [31:0] bin_value;
      logic [31:0]        group_hits;
      logic [1:0]         status;
   } hist_response_type;

   class histogram_scoreboard;
      logic [2:0]        map_entries [TABLE_SIZE];
      int                spectrum [NUM_GROUPS * BINS];
      int unsigned       hit_count [NUM_GROUPS];
      int                scale_reg;
      int                shift_reg;
      hist_response_type expected_responses [$];
      int                mismatches;

      function new();
         foreach (map_entries[i]) map_entries[i] = '0;
         foreach (spectrum[i]) spectrum[i] = 0;
         foreach (hit_count[i]) hit_count[i] = 0;
         scale_reg = int'(gwh_pkg::SCALE_RESET);
         shift_reg = int'(gwh_pkg::SHIFT_RESET);
         mismatches = 0;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] data);
         case (index)
            gwh_pkg::CSR_SCALE: scale_reg = int'(data[15:0]);
            gwh_pkg::CSR_SHIFT: shift_reg = int'($signed(data));
            default: ;
         endcase
      endfunction

      function int table_slot(hist_request_type r);
         if (r.position < 1 || r.position > NUM_POS || r.colour >= gwh_pkg::NUM_COLOUR ||
             r.recoil_det < 1 || r.recoil_det > NUM_RECOIL)
            return -1;
         return int'(((r.position - 1) * gwh_pkg::NUM_COLOUR + r.colour) * NUM_RECOIL
                     + r.recoil_det - 1);
      endfunction

      function void note_request(hist_request_type r);
         hist_response_type e;
         int                slot;
         int unsigned       g;
         int                idx;
         longint            scaled;
         longint            total;
         e.bin_value = '0;
         e.group_hits = '0;
         e.status = gwh_pkg::ST_RANGE;
         slot = table_slot(r);
         case (r.kind)
            gwh_pkg::KIND_MAP: begin
               if (slot >= 0 && r.map_group < NUM_GROUPS) begin
                  map_entries[slot] = r.map_group;
                  e.status = gwh_pkg::ST_OK;
               end
            end
            gwh_pkg::KIND_HIT: begin
               if (slot >= 0) begin
                  g = map_entries[slot] % NUM_GROUPS;
                  e.status = gwh_pkg::ST_SKIP;
                  if (r.energy >= 0) begin
                     scaled = longint'(r.energy) * scale_reg + shift_reg;
                     if (hit_count[g] != 32'hFFFF_FFFF) hit_count[g]++;
                     if (scaled >= 0 && (scaled >>> gwh_pkg::FRAC_BITS) < BINS) begin
                        idx = int'(g) * BINS + int'(scaled >>> gwh_pkg::FRAC_BITS);
                        total = longint'(spectrum[idx]) + r.weight;
                        if (total > 64'sd2147483647) total = 64'sd2147483647;
                        if (total < -64'sd2147483648) total = -64'sd2147483648;
                        spectrum[idx] = int'(total);
                        e.bin_value = 32'(total);
                        e.status = gwh_pkg::ST_OK;
                     end
                  end
                  e.group_hits = hit_count[g];
               end
            end
            gwh_pkg::KIND_READ: begin
               if (r.map_group < NUM_GROUPS && r.read_bin < BINS) begin
                  e.bin_value = spectrum[int'(r.map_group) * BINS + int'(r.read_bin)];
                  e.group_hits = hit_count[r.map_group];
                  e.status = gwh_pkg::ST_OK;
               end
            end
            default: ;
         endcase
         expected_responses.push_back(e);
      endfunction

      function void check_response(hist_response_type got);
         hist_response_type e;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Response transaction with none outstanding: %0d %0d %0d",
                        got.bin_value, got.group_hits, got.status);
         end else begin
            e = expected_responses.pop_front();
            if (got.bin_value !== e.bin_value || got.group_hits !== e.group_hits ||
                got.status !== e.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Mismatch at %0t: expected %0d %0d %0d, got %0d %0d %0d",
                           $realtime, e.bin_value, e.group_hits, e.status,
                           got.bin_value, got.group_hits, got.status);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = '0;
   logic [4:0]         req_position = '0;
   logic [2:0]         req_colour = '0;
   logic [4:0]         req_recoil_det = '0;
   logic [2:0]         req_map_group = '0;
   logic signed [19:0] req_energy = '0;
   logic signed [15:0] req_weight = '0;
   logic [11:0]        req_read_bin = '0;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_bin_value;
   logic [31:0]        rsp_group_hits;
   logic [1:0]         rsp_status;

   histogram_scoreboard sb;
   int hot_bins [8];

   gated_weighted_histogram_unit #(
      .NUM_GROUPS (NUM_GROUPS),
      .BINS       (BINS),
      .NUM_POS    (NUM_POS),
      .NUM_RECOIL (NUM_RECOIL)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_colour     (req_colour),
      .req_recoil_det (req_recoil_det),
      .req_map_group  (req_map_group),
      .req_energy     (req_energy),
      .req_weight     (req_weight),
      .req_read_bin   (req_read_bin),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_bin_value  (rsp_bin_value),
      .rsp_group_hits (rsp_group_hits),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      hist_response_type got;
      if (!reset && rsp_valid) begin
         got.bin_value = rsp_bin_value;
         got.group_hits = rsp_group_hits;
         got.status = rsp_status;
         sb.check_response(got);
      end
   end

   function automatic hist_request_type make_request(logic [1:0] kind,
                                                     logic [4:0] position,
                                                     logic [2:0] colour,
                                                     logic [4:0] recoil_det,
                                                     logic [2:0] map_group,
                                                     logic signed [19:0] energy,
                                                     logic signed [15:0] weight,
                                                     logic [11:0] read_bin);
      hist_request_type r;
      r.kind = kind;
      r.position = position;
      r.colour = colour;
      r.recoil_det = recoil_det;
      r.map_group = map_group;
      r.energy = energy;
      r.weight = weight;
      r.read_bin = read_bin;
      return r;
   endfunction

   function automatic logic signed [19:0] energy_for_bin(int b);
      longint target;
      longint e;
      if (sb.scale_reg == 0) return 20'($urandom_range(0, 524287));
      target = longint'(b) * 4096 + 2048 - sb.shift_reg;
      e = target / sb.scale_reg;
      if (target < 0 || e > 524287) return 20'($urandom_range(0, 524287));
      return 20'(e);
   endfunction

   function automatic void choose_hot_bins();
      longint lo;
      longint hi;
      lo = longint'(sb.shift_reg) >>> gwh_pkg::FRAC_BITS;
      hi = (longint'(524287) * sb.scale_reg + sb.shift_reg) >>> gwh_pkg::FRAC_BITS;
      if (lo < 0) lo = 0;
      if (hi > BINS - 1) hi = BINS - 1;
      if (lo > hi) begin
         lo = 0;
         hi = BINS - 1;
      end
      foreach (hot_bins[i]) hot_bins[i] = $urandom_range(int'(hi), int'(lo));
   endfunction

   function automatic hist_request_type random_request();
      hist_request_type r;
      int               pick;
      int               energy_pick;
      r = make_request(gwh_pkg::KIND_HIT, 5'($urandom_range(1, NUM_POS)),
                       3'($urandom_range(0, gwh_pkg::NUM_COLOUR - 1)),
                       5'($urandom_range(1, NUM_RECOIL)), 3'($urandom()),
                       20'($urandom()), 16'($urandom()),
                       12'(hot_bins[$urandom_range(0, 7)]));
      if ($urandom_range(0, 9) == 0) begin
         r.position = 5'($urandom());
         r.colour = 3'($urandom());
         r.recoil_det = 5'($urandom());
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.kind = gwh_pkg::KIND_MAP;
      end else if (pick < 65) begin
         energy_pick = $urandom_range(0, 99);
         if (energy_pick < 55)
            r.energy = energy_for_bin(hot_bins[$urandom_range(0, 7)]);
         else if (energy_pick < 70)
            r.energy = energy_for_bin($urandom_range(0, BINS - 1));
         else if (energy_pick < 85)
            r.energy = {1'b1, 19'($urandom())};
      end else if (pick < 90) begin
         r.kind = gwh_pkg::KIND_READ;
         if ($urandom_range(0, 2) == 0) r.read_bin = 12'($urandom());
      end else if (pick < 95) begin
         r.kind = KIND_UNUSED;
      end else begin
         r.kind = 2'($urandom());
         r.position = 5'($urandom());
         r.colour = 3'($urandom());
         r.recoil_det = 5'($urandom());
         r.read_bin = 12'($urandom());
      end
      return r;
   endfunction

   task automatic send_request(input hist_request_type r);
      @(negedge clock);
      start = 1'b1;
      req_kind = r.kind;
      req_position = r.position;
      req_colour = r.colour;
      req_recoil_det = r.recoil_det;
      req_map_group = r.map_group;
      req_energy = r.energy;
      req_weight = r.weight;
      req_read_bin = r.read_bin;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
         start = 1'b0;
      end while (busy || sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic configure(input int phase);
      logic [15:0] scale;
      logic [31:0] shift;
      case (phase)
         0: begin
            scale = gwh_pkg::SCALE_RESET;
            shift = gwh_pkg::SHIFT_RESET;
         end
         1: begin
            scale = 16'hFFFF;
            shift = 32'h8000_0000;
         end
         2: begin
            scale = 16'h0000;
            shift = 32'h7FFF_FFFF;
         end
         3: begin
            scale = 16'd1;
            shift = 32'd0;
         end
         4: begin
            scale = 16'($urandom_range(1, 65535));
            shift = 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
         end
         5: begin
            scale = 16'($urandom());
            shift = $urandom();
         end
         default: begin
            scale = gwh_pkg::SCALE_RESET;
            shift = 32'hFFF0_0000;
         end
      endcase
      drain();
      write_csr(gwh_pkg::CSR_SCALE, {16'($urandom()), scale});
      write_csr(gwh_pkg::CSR_SHIFT, shift);
      write_csr(phase % 2 == 0 ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
   endtask

   initial begin
      sb = new();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset gain and offset.
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd1, 3'd0, 5'd1, 3'd7,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd16, 3'd3, 5'd24, 3'd5,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd0, 3'd0, 5'd1, 3'd1,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd17, 3'd2, 5'd5, 3'd1,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd31, 3'd7, 5'd31, 3'd7,
                                -20'sd1, -16'sd1, 12'hFFF));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd3, 3'd4, 5'd5, 3'd2,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd3, 3'd2, 5'd0, 3'd2,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd3, 3'd2, 5'd25, 3'd2,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd0, 16'sd32767, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd65535, -16'sd32768, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd65536, 16'sd5, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd524287, -16'sd1, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd1, 3'd0, 5'd1, 3'd0,
                                -20'sd1, 16'sd7, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd1, 3'd0, 5'd1, 3'd0,
                                -20'sd524288, 16'sd7, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd1, 3'd0, 5'd1, 3'd0,
                                20'sd16, 16'sd256, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd0, 3'd0, 5'd0, 3'd0,
                                20'sd16, 16'sd256, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd4, 5'd24, 3'd0,
                                20'sd16, 16'sd256, 12'd0));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd5,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd5,
                                20'sd0, 16'sd0, 12'hFFF));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd7,
                                20'sd0, 16'sd0, 12'd1));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd0,
                                20'sd0, 16'sd0, 12'd0));
      send_request(make_request(KIND_UNUSED, 5'd31, 3'd7, 5'd31, 3'd7,
                                -20'sd1, -16'sd1, 12'hFFF));
      send_request(make_request(KIND_UNUSED, 5'd0, 3'd0, 5'd0, 3'd0,
                                20'sd0, 16'sd0, 12'd0));

      // A negative offset pushes a zero energy below the first bin.
      drain();
      write_csr(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      write_csr(gwh_pkg::CSR_SHIFT, 32'hFFFF_F000);
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd0, 16'sd3, 12'd0));
      send_request(make_request(gwh_pkg::KIND_HIT, 5'd16, 3'd3, 5'd24, 3'd0,
                                20'sd16, 16'sd3, 12'd0));

      // Large positive and negative weights pile up in two bins of one group.
      drain();
      write_csr(gwh_pkg::CSR_SHIFT, gwh_pkg::SHIFT_RESET);
      send_request(make_request(gwh_pkg::KIND_MAP, 5'd2, 3'd1, 5'd3, 3'd3,
                                20'sd0, 16'sd0, 12'd0));
      repeat (HEAVY_HITS)
         send_request(make_request(gwh_pkg::KIND_HIT, 5'd2, 3'd1, 5'd3, 3'd0,
                                   20'sd1600, 16'sd32767, 12'd0));
      repeat (HEAVY_HITS)
         send_request(make_request(gwh_pkg::KIND_HIT, 5'd2, 3'd1, 5'd3, 3'd0,
                                   20'sd3200, -16'sd32768, 12'd0));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd3,
                                20'sd0, 16'sd0, 12'd100));
      send_request(make_request(gwh_pkg::KIND_READ, 5'd0, 3'd0, 5'd0, 3'd3,
                                20'sd0, 16'sd0, 12'd200));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         configure(phase);
         choose_hot_bins();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_request());
            if (phase < NUM_PHASES - 1 && n % 64 < 40 && $urandom_range(0, 3) == 0)
               hold_off($urandom_range(1, 9));
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
